/* hdl/svgf_pkg.sv */
package svgf_pkg;

   localparam int unsigned Q_ONE = 65536;
   localparam logic [15:0] ALBEDO_FLOOR = 16'd66;
   localparam logic [15:0] LUM_WR = 16'd13933;
   localparam logic [15:0] LUM_WG = 16'd46871;
   localparam logic [15:0] LUM_WB = 16'd4732;

   // configuration register indexes
   localparam logic CSR_COLOR_ALPHA = 1'b0;
   localparam logic CSR_MOMENT_WEIGHT = 1'b1;

   // side data of the request word as carried through the pipeline
   typedef struct packed {
      logic [31:0] prev_m2;
      logic [15:0] prev_m1;
      logic [47:0] prev_illum;
      logic [5:0]  prev_len;
      logic        reproj;
      logic        valid;
      logic [47:0] radiance;
   } side_type;

   // lane divider control
   typedef struct packed {
      logic [15:0] light;
      logic [15:0] divisor;
   } div_ctl_type;

   // weights
   function automatic logic [16:0] clamp_alpha(input logic [16:0] reg_value);
      logic [16:0] res;
      res = (reg_value > 17'(Q_ONE)) ? 17'(Q_ONE) : reg_value;
      return res;
   endfunction

endpackage

/* hdl/svgf_lane.sv */
// One color channel lane: restoring divider, one quotient bit per pipeline stage.
// Quotient of (light << 16) / divisor, saturated to 16 bits; 34 register stages
// from the inputs to the quotient.
module svgf_lane (
   input  logic                       clock,
   input  logic                       advance,
   input  svgf_pkg::div_ctl_type      ctl,
   output logic [15:0]                quot
);

   localparam int unsigned QBITS = 32;

   // remainder, divisor and quotient per stage
   logic [16:0] rem_ff   [QBITS+1];
   logic [15:0] dvs_ff   [QBITS+1];
   logic [31:0] num_ff   [QBITS+1];
   logic [31:0] q_ff     [QBITS+1];
   logic [15:0] quot_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= '0;
         dvs_ff[0] <= ctl.divisor;
         num_ff[0] <= {ctl.light, 16'd0};
         q_ff[0]   <= '0;
         for (int i = 0; i < QBITS; i++) begin
            logic [17:0] trial;
            trial = {rem_ff[i], num_ff[i][31]};
            if (trial >= {2'b00, dvs_ff[i]}) begin
               rem_ff[i+1] <= 17'(trial - {2'b00, dvs_ff[i]});
               q_ff[i+1]   <= {q_ff[i][30:0], 1'b1};
            end else begin
               rem_ff[i+1] <= trial[16:0];
               q_ff[i+1]   <= {q_ff[i][30:0], 1'b0};
            end
            dvs_ff[i+1] <= dvs_ff[i];
            num_ff[i+1] <= {num_ff[i][30:0], 1'b0};
         end
         // saturate
         quot_ff <= (q_ff[QBITS][31:16] != '0) ? 16'hFFFF : q_ff[QBITS][15:0];
      end
   end

   assign quot = quot_ff;

endmodule

/* hdl/svgf_merge.sv */
// Merge stage: luminance, blend, variance over registered steps.
module svgf_merge #(
   parameter int unsigned MAX_HISTORY = 32
) (
   input  logic                 clock,
   input  logic                 advance,
   input  logic [47:0]          ill_in,
   input  svgf_pkg::side_type   side,
   input  logic [16:0]          color_alpha,
   input  logic [16:0]          moment_weight,
   output logic [47:0]          illum_rgb,
   output logic [15:0]          moment_one,
   output logic [31:0]          moment_two,
   output logic [31:0]          variance_out,
   output logic [5:0]           length_out
);

   localparam int unsigned LEN_W = $clog2(MAX_HISTORY + 2);
   localparam int unsigned RECIP_DEPTH = 2 ** LEN_W;

   // stage 1: luminance products, length, reciprocal
   logic [31:0] pr_ff, pg_ff, pb_ff;
   logic [47:0] ill1_ff;
   svgf_pkg::side_type s1_ff;
   logic [LEN_W-1:0] len1_ff;
   logic [16:0] ca1_ff, ma1_ff;

   // stage 2: lum
   logic [15:0] lum2_ff;
   logic [47:0] ill2_ff;
   svgf_pkg::side_type s2_ff;
   logic [LEN_W-1:0] len2_ff;
   logic [16:0] ca2_ff, ma2_ff;

   // stage 3: m2 square and blend products
   logic [31:0] m2new3_ff;
   logic [15:0] lum3_ff;
   logic [32:0] ih_ff [3];
   logic [32:0] ic_ff [3];
   logic [32:0] m1h_ff, m1c_ff;
   logic [47:0] ill3_ff;
   svgf_pkg::side_type s3_ff;
   logic [LEN_W-1:0] len3_ff;
   logic [16:0] ma3_ff;

   // stage 4: blended illum, m1, m2 products
   logic [47:0] ill4_ff;
   logic [15:0] m1_4_ff;
   logic [48:0] m2h_ff, m2c_ff;
   svgf_pkg::side_type s4_ff;
   logic [LEN_W-1:0] len4_ff;
   logic [31:0] m2new4_ff;

   // stage 5: m2 and m1 squared
   logic [47:0] ill5_ff;
   logic [15:0] m1_5_ff;
   logic [31:0] m2_5_ff, m1sq5_ff;
   svgf_pkg::side_type s5_ff;
   logic [LEN_W-1:0] len5_ff;

   // stage 6: output
   logic [47:0] out_ill_ff;
   logic [15:0] out_m1_ff;
   logic [31:0] out_m2_ff, out_var_ff;
   logic [5:0]  out_len_ff;

   logic [LEN_W-1:0] len_in;
   logic [16:0] recip;
   logic [16:0] recip_tab [RECIP_DEPTH];

   always_comb begin
      if (!side.reproj) begin
         len_in = LEN_W'(1);
      end else if (32'(side.prev_len) >= MAX_HISTORY) begin
         len_in = LEN_W'(MAX_HISTORY);
      end else begin
         len_in = LEN_W'(side.prev_len) + LEN_W'(1);
      end
   end

   // small reciprocal table over the length range
   for (genvar k = 0; k < RECIP_DEPTH; k++) begin : g_recip
      localparam int unsigned RECIP_DEN = (k == 0 || k > MAX_HISTORY) ? 1 : k;
      localparam logic [16:0] RECIP_VAL = 17'(svgf_pkg::Q_ONE / RECIP_DEN);
      assign recip_tab[k] = RECIP_VAL;
   end

   assign recip = recip_tab[len_in];

   always_ff @(posedge clock) begin
      if (advance) begin
         logic [16:0] cac, mac;
         cac = svgf_pkg::clamp_alpha(color_alpha);
         mac = svgf_pkg::clamp_alpha(moment_weight);
         pr_ff <= ill_in[15:0]  * svgf_pkg::LUM_WR;
         pg_ff <= ill_in[31:16] * svgf_pkg::LUM_WG;
         pb_ff <= ill_in[47:32] * svgf_pkg::LUM_WB;
         ill1_ff <= ill_in;
         s1_ff <= side;
         len1_ff <= len_in;
         ca1_ff <= (recip > cac) ? recip : cac;
         ma1_ff <= (recip > mac) ? recip : mac;

         lum2_ff <= 16'((34'(pr_ff) + 34'(pg_ff) + 34'(pb_ff) + 34'd32768) >> 16);
         ill2_ff <= ill1_ff;
         s2_ff <= s1_ff;
         len2_ff <= len1_ff;
         ca2_ff <= s1_ff.reproj ? ca1_ff : 17'(svgf_pkg::Q_ONE);
         ma2_ff <= s1_ff.reproj ? ma1_ff : 17'(svgf_pkg::Q_ONE);

         m2new3_ff <= lum2_ff * lum2_ff;
         lum3_ff <= lum2_ff;
         for (int c = 0; c < 3; c++) begin
            ih_ff[c] <= s2_ff.prev_illum[c*16 +: 16] * (17'(svgf_pkg::Q_ONE) - ca2_ff);
            ic_ff[c] <= ill2_ff[c*16 +: 16] * ca2_ff;
         end
         m1h_ff <= s2_ff.prev_m1 * (17'(svgf_pkg::Q_ONE) - ma2_ff);
         m1c_ff <= lum2_ff * ma2_ff;
         ill3_ff <= ill2_ff;
         s3_ff <= s2_ff;
         len3_ff <= len2_ff;
         ma3_ff <= ma2_ff;

         for (int c = 0; c < 3; c++) begin
            ill4_ff[c*16 +: 16] <= 16'((34'(ih_ff[c]) + 34'(ic_ff[c]) + 34'd32768) >> 16);
         end
         m1_4_ff <= 16'((34'(m1h_ff) + 34'(m1c_ff) + 34'd32768) >> 16);
         m2h_ff <= s3_ff.prev_m2 * (17'(svgf_pkg::Q_ONE) - ma3_ff);
         m2c_ff <= m2new3_ff * ma3_ff;
         s4_ff <= s3_ff;
         len4_ff <= len3_ff;
         m2new4_ff <= m2new3_ff;

         ill5_ff <= ill4_ff;
         m1_5_ff <= m1_4_ff;
         m2_5_ff <= 32'((50'(m2h_ff) + 50'(m2c_ff) + 50'd32768) >> 16);
         m1sq5_ff <= m1_4_ff * m1_4_ff;
         s5_ff <= s4_ff;
         len5_ff <= len4_ff;

         if (!s5_ff.valid) begin
            out_ill_ff <= s5_ff.radiance;
            out_m1_ff <= '0;
            out_m2_ff <= '0;
            out_var_ff <= '0;
            out_len_ff <= '0;
         end else begin
            out_ill_ff <= ill5_ff;
            out_m1_ff <= m1_5_ff;
            out_m2_ff <= m2_5_ff;
            out_var_ff <= (m2_5_ff > m1sq5_ff) ? m2_5_ff - m1sq5_ff : '0;
            out_len_ff <= (len5_ff > LEN_W'(63)) ? 6'd63 : 6'(len5_ff);
         end
      end
   end

   assign illum_rgb = out_ill_ff;
   assign moment_one = out_m1_ff;
   assign moment_two = out_m2_ff;
   assign variance_out = out_var_ff;
   assign length_out = out_len_ff;

endmodule

/* hdl/svgf_temporal_accumulate.sv */
// Pipeline: 40 register stages (34 divider, 6 merge); the response word can be taken
// once its request word has passed through all of them.
// Throughput: one word per cycle unless stalled; three divider lanes, one quotient bit/stage.
// The pipeline advances whenever the output stage is empty or being taken.
// Reset: synchronous, active high; clears valid bits and sets both alphas to 13107.
module svgf_temporal_accumulate #(
   parameter int unsigned MAX_HISTORY = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata from bit 0: radiance_rgb, emission_rgb, albedo_rgb, prev_illum_rgb,
   // prev_moment_one, prev_moment_two, prev_length, zero fill
   input  logic [247:0] req_tdata,
   // tuser from bit 0: surface_valid, reprojected
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata from bit 0: illum_rgb, moment_one, moment_two, variance_out, length_out, zero fill
   output logic [135:0] rsp_tdata,
   input  logic         csr_wr_en,
   input  logic         csr_index,
   input  logic [16:0]  csr_wdata
);

   localparam int unsigned DIV_LAT = 34;
   localparam int unsigned LAT = DIV_LAT + 6;

   logic [16:0] color_alpha_ff, moment_weight_ff;
   logic [LAT-1:0] vld_ff;
   logic advance;
   svgf_pkg::side_type side_ff [DIV_LAT];
   svgf_pkg::side_type side_in;
   svgf_pkg::div_ctl_type ctl [3];
   logic [47:0] quot;
   logic [47:0] illum;
   logic [15:0] m1;
   logic [31:0] m2, var_w;
   logic [5:0] len;

   assign advance = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = advance && !reset;
   assign rsp_tvalid = vld_ff[LAT-1];

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         color_alpha_ff <= 17'd13107;
         moment_weight_ff <= 17'd13107;
      end else if (csr_wr_en) begin
         case (csr_index)
            svgf_pkg::CSR_COLOR_ALPHA:   color_alpha_ff <= csr_wdata;
            svgf_pkg::CSR_MOMENT_WEIGHT: moment_weight_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // valid pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   assign side_in = '{prev_m2: req_tdata[239:208], prev_m1: req_tdata[207:192],
                      prev_illum: req_tdata[191:144], prev_len: req_tdata[245:240],
                      reproj: req_tuser[1], valid: req_tuser[0],
                      radiance: req_tdata[47:0]};

   // side data delay line matching divider lanes
   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < DIV_LAT; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   // lane inputs: lighting and floored albedo
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         logic [15:0] r, e, a;
         r = req_tdata[c*16 +: 16];
         e = req_tdata[48 + c*16 +: 16];
         a = req_tdata[96 + c*16 +: 16];
         ctl[c].light = (r > e) ? r - e : '0;
         ctl[c].divisor = (a < svgf_pkg::ALBEDO_FLOOR) ? svgf_pkg::ALBEDO_FLOOR : a;
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_lane
      svgf_lane u_lane (
         .clock   (clock),
         .advance (advance),
         .ctl     (ctl[c]),
         .quot    (quot[c*16 +: 16])
      );
   end

   svgf_merge #(.MAX_HISTORY(MAX_HISTORY)) u_merge (
      .clock         (clock),
      .advance       (advance),
      .ill_in        (quot),
      .side          (side_ff[DIV_LAT-1]),
      .color_alpha   (color_alpha_ff),
      .moment_weight (moment_weight_ff),
      .illum_rgb     (illum),
      .moment_one    (m1),
      .moment_two    (m2),
      .variance_out  (var_w),
      .length_out    (len)
   );

   assign rsp_tdata = {2'b00, len, var_w, m2, m1, illum};

endmodule

/* sim/tb_svgf_temporal_accumulate.sv */
module tb_svgf_temporal_accumulate;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [47:0] radiance;
      logic [47:0] emission;
      logic [47:0] albedo;
      logic        valid;
      logic        reproj;
      logic [47:0] prev_illum;
      logic [15:0] prev_m1;
      logic [31:0] prev_m2;
      logic [5:0]  prev_len;
   } pixel_type;

   typedef struct {
      logic [47:0] illum;
      logic [15:0] m1;
      logic [31:0] m2;
      logic [31:0] variance;
      logic [5:0]  len;
   } accum_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [247:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [135:0] rsp_tdata;
   logic         csr_wr_en = 1'b0;
   logic         csr_index = 1'b0;
   logic [16:0]  csr_wdata = '0;

   // testbench copy of the weight registers
   logic [16:0]  color_alpha_q = 17'd13107;
   logic [16:0]  moment_weight_q = 17'd13107;

   accum_type    accum_q[$];
   int           errors = 0;
   int           sink_hold = 0;   // cycles of forced back-pressure
   bit           sink_free = 0;   // no random stalls
   bit           send_free = 0;   // no random gaps

   localparam int HISTORY_CAP = 32;

   always #4 clock = ~clock;

   svgf_temporal_accumulate #(.MAX_HISTORY(HISTORY_CAP)) u_top (.*);

   function automatic logic [63:0] mix(logic [63:0] hist, logic [63:0] cur, logic [63:0] t);
      return (hist * (64'd65536 - t) + cur * t + 64'd32768) >> 16;
   endfunction

   // expected accumulation of one pixel
   function automatic accum_type accumulate(pixel_type p);
      accum_type   r;
      logic [63:0] ill[3];
      logic [63:0] light, div, q, lum, m1, m2, len, recip, ca, ma, sq;
      r.illum = p.radiance;
      r.m1 = '0; r.m2 = '0; r.variance = '0; r.len = '0;
      if (!p.valid) return r;
      for (int c = 0; c < 3; c++) begin
         light = (p.radiance[16*c +: 16] > p.emission[16*c +: 16]) ?
                 p.radiance[16*c +: 16] - p.emission[16*c +: 16] : 0;
         div = (p.albedo[16*c +: 16] < 66) ? 64'd66 : 64'(p.albedo[16*c +: 16]);
         q = (light << 16) / div;
         ill[c] = (q > 64'hFFFF) ? 64'hFFFF : q;
      end
      lum = (64'd13933 * ill[0] + 64'd46871 * ill[1] + 64'd4732 * ill[2] + 64'd32768) >> 16;
      m1 = lum;
      m2 = lum * lum;
      if (p.reproj) begin
         len = p.prev_len + 1;
         if (len > HISTORY_CAP) len = HISTORY_CAP;
         if (len < 1) len = 1;
         recip = 64'd65536 / len;
         ca = (color_alpha_q > 17'd65536) ? 64'd65536 : 64'(color_alpha_q);
         ma = (moment_weight_q > 17'd65536) ? 64'd65536 : 64'(moment_weight_q);
         if (recip > ca) ca = recip;
         if (recip > ma) ma = recip;
         for (int c = 0; c < 3; c++) ill[c] = mix(p.prev_illum[16*c +: 16], ill[c], ca);
         m1 = mix(p.prev_m1, m1, ma);
         m2 = mix(p.prev_m2, m2, ma);
      end else begin
         len = 1;
      end
      if (len > 63) len = 63;
      for (int c = 0; c < 3; c++) r.illum[16*c +: 16] = ill[c][15:0];
      sq = m1 * m1;
      r.m1 = m1[15:0];
      r.m2 = m2[31:0];
      r.variance = (m2 > sq) ? 32'(m2 - sq) : 32'd0;
      r.len = len[5:0];
      return r;
   endfunction

   // send one pixel word, with random gaps unless send_free is set
   task automatic send_pixel(pixel_type p);
      if (!send_free) begin
         while ($urandom_range(99) < 13) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'd0, p.prev_len, p.prev_m2, p.prev_m1, p.prev_illum,
                    p.albedo, p.emission, p.radiance};
      req_tuser <= {p.reproj, p.valid};
      accum_q.push_back(accumulate(p));
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic pixel_type rand_pixel();
      pixel_type p;
      p.radiance = 48'({$urandom, $urandom});
      p.emission = ($urandom_range(3) == 0) ? 48'({$urandom, $urandom}) : 48'd0;
      if ($urandom_range(3) == 0) p.emission = p.emission & {3{16'h00FF}};
      p.albedo = 48'({$urandom, $urandom});
      if ($urandom_range(4) == 0) p.albedo = p.albedo & {3{16'h00FF}};
      p.valid = ($urandom_range(9) != 0);
      p.reproj = ($urandom_range(4) != 0);
      p.prev_illum = 48'({$urandom, $urandom});
      p.prev_m1 = 16'($urandom);
      p.prev_m2 = $urandom;
      p.prev_len = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(32));
      return p;
   endfunction

   task automatic drain();
      req_tvalid <= 1'b0;
      while (accum_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [16:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == svgf_pkg::CSR_COLOR_ALPHA) color_alpha_q = val;
      else moment_weight_q = val;
      @(posedge clock);
   endtask

   // directed corner pixels
   task automatic test_directed();
      pixel_type p;
      for (int k = 0; k < 20; k++) begin
         p = rand_pixel();
         p.valid = 1'b1;
         case (k)
            0: p.valid = 1'b0;
            1: begin p.valid = 1'b0; p.radiance = '1; end
            2: p.reproj = 1'b0;
            3: begin p.reproj = 1'b1; p.prev_len = 6'd0; end
            4: p.prev_len = 6'd31;
            5: p.prev_len = 6'd32;
            6: p.prev_len = 6'd63;
            7: begin p.albedo = '0; p.emission = '0; end
            8: begin p.albedo = '1; p.radiance = '1; p.emission = '0; end
            9: p.emission = '1;
            10: begin p.radiance = '0; p.emission = '0; p.prev_m2 = '1; p.prev_m1 = '0; end
            11: begin p.prev_illum = '1; p.prev_m1 = '1; p.prev_m2 = '1; end
            12: begin p.prev_illum = '0; p.prev_m1 = '0; p.prev_m2 = '0; end
            13: begin p.albedo = {3{16'd65}}; p.emission = '0; end
            14: begin p.albedo = {3{16'd66}}; p.radiance = {3{16'd1}}; p.emission = '0; end
            default: ;
         endcase
         send_pixel(p);
      end
      drain();
   endtask

   // random pixels under one weight setting
   task automatic test_random(int n);
      for (int k = 0; k < n; k++) send_pixel(rand_pixel());
      drain();
   endtask

   // fill the pipeline against a stalled output
   task automatic test_backpressure();
      sink_hold = 120;
      send_free = 1;
      for (int k = 0; k < 100; k++) send_pixel(rand_pixel());
      send_free = 0;
      drain();
   endtask

   // response sink and checker
   always @(posedge clock) begin
      accum_type e, a;
      if (rsp_tvalid && rsp_tready) begin
         a.illum = rsp_tdata[47:0];
         a.m1 = rsp_tdata[63:48];
         a.m2 = rsp_tdata[95:64];
         a.variance = rsp_tdata[127:96];
         a.len = rsp_tdata[133:128];
         if (accum_q.size() == 0) begin
            $error("unexpected response word %h", rsp_tdata);
            errors++;
         end else begin
            e = accum_q.pop_front();
            if (a.illum !== e.illum) begin
               $error("illum_rgb exp %h got %h", e.illum, a.illum); errors++;
            end
            if (a.m1 !== e.m1) begin
               $error("moment_one exp %h got %h", e.m1, a.m1); errors++;
            end
            if (a.m2 !== e.m2) begin
               $error("moment_two exp %h got %h", e.m2, a.m2); errors++;
            end
            if (a.variance !== e.variance) begin
               $error("variance_out exp %h got %h", e.variance, a.variance); errors++;
            end
            if (a.len !== e.len) begin
               $error("length_out exp %0d got %0d", e.len, a.len); errors++;
            end
         end
      end
      if (sink_hold > 0) begin
         sink_hold <= sink_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= reset ? 1'b0 : (sink_free || $urandom_range(99) >= 13);
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      write_csr(svgf_pkg::CSR_COLOR_ALPHA, 17'd0);
      write_csr(svgf_pkg::CSR_MOMENT_WEIGHT, 17'd65536);
      test_random(400);
      write_csr(svgf_pkg::CSR_COLOR_ALPHA, 17'h1FFFF);
      write_csr(svgf_pkg::CSR_MOMENT_WEIGHT, 17'd0);
      test_random(300);
      test_backpressure();
      write_csr(svgf_pkg::CSR_COLOR_ALPHA, 17'd65536);
      write_csr(svgf_pkg::CSR_MOMENT_WEIGHT, 17'h1FFFF);
      test_random(300);
      write_csr(svgf_pkg::CSR_COLOR_ALPHA, 17'($urandom));
      write_csr(svgf_pkg::CSR_MOMENT_WEIGHT, 17'($urandom_range(65536)));
      sink_free = 1;
      send_free = 1;
      test_random(400);
      sink_free = 0;
      send_free = 0;
      write_csr(svgf_pkg::CSR_COLOR_ALPHA, 17'd13107);
      write_csr(svgf_pkg::CSR_MOMENT_WEIGHT, 17'd13107);
      test_random(500);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("TB_ERROR");
      $finish;
   end
endmodule
